>>> rtl/qrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_pkg: shared types and constants for the quadratic root solver
// Widths of the square root and divider chains and the beat structs that
// travel from cell to cell.
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 34;
  localparam int RAD_W      = 64;
  localparam int REM_W      = 34;
  localparam int ROOT_W     = 32;
  localparam int DVD_W      = 34;
  localparam int DEN_W      = 16;

  typedef enum logic [1:0] {
    KIND_REAL    = 2'd0,
    KIND_COMPLEX = 2'd1,
    KIND_DEGEN   = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic               a_neg;
    logic [DEN_W-1:0]   a_mag;
    logic signed [31:0] nb;
  } sqrt_side_t;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_work_t;

  typedef struct packed {
    kind_t            kind;
    logic             neg1;
    logic             neg2;
    logic [DEN_W-1:0] den;
  } div_side_t;

  typedef struct packed {
    logic [DVD_W-1:0] dq1;
    logic [DEN_W-1:0] rem1;
    logic [DVD_W-1:0] dq2;
    logic [DEN_W-1:0] rem2;
  } div_work_t;

endpackage
`default_nettype wire

>>> rtl/qrs_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_front: coefficient products and discriminant
// Registers b*b and a*c, then forms the discriminant magnitude, the root kind
// and the scaled -b term for the square root chain.
// ----------------------------------------------------------------------------
module qrs_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic signed [15:0]  coef_a,
  input  wire logic signed [15:0]  coef_b,
  input  wire logic signed [15:0]  coef_c,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output qrs_pkg::sqrt_side_t      out_side,
  output qrs_pkg::sqrt_work_t      out_work
);
  import qrs_pkg::*;

  logic               valid;
  logic signed [31:0] bb;
  logic signed [31:0] ac;
  logic signed [15:0] a;
  logic signed [15:0] b;
  logic signed [33:0] d;
  logic [32:0]        d_mag;
  logic signed [16:0] b_neg;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      bb <= coef_b * coef_b;
      ac <= coef_a * coef_c;
      a  <= coef_a;
      b  <= coef_b;
    end
  end

  always_comb begin
    d     = {{2{bb[31]}}, bb} - {ac, 2'b00};
    d_mag = d[33] ? 33'(-d) : d[32:0];
    b_neg = -{b[15], b};
    out_side.nb    = {b_neg[16:0], 15'd0};
    out_side.a_neg = a[15];
    out_side.a_mag = a[15] ? DEN_W'(-{a[15], a}) : DEN_W'(a);
    if (a == 16'sd0) begin
      out_side.kind = KIND_DEGEN;
    end else if (d[33]) begin
      out_side.kind = KIND_COMPLEX;
    end else begin
      out_side.kind = KIND_REAL;
    end
    out_work.rad  = {1'b0, d_mag, 30'd0};
    out_work.rem  = '0;
    out_work.root = '0;
  end

endmodule
`default_nettype wire

>>> rtl/qrs_sqrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_sqrt_cell: one digit of the integer square root
// Brings down two radicand bits, tries the next root bit and hands the
// partial remainder and root to the next cell.
// ----------------------------------------------------------------------------
module qrs_sqrt_cell (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire qrs_pkg::sqrt_side_t in_side,
  input  wire qrs_pkg::sqrt_work_t in_work,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output qrs_pkg::sqrt_side_t      out_side,
  output qrs_pkg::sqrt_work_t      out_work
);
  import qrs_pkg::*;

  logic       valid;
  sqrt_work_t work_next;
  logic [REM_W+1:0] cur;
  logic [REM_W+1:0] trial;
  logic             ge;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  always_comb begin
    cur   = {in_work.rem, in_work.rad[RAD_W-1 -: 2]};
    trial = (REM_W+2)'({in_work.root, 2'b01});
    ge    = cur >= trial;
    work_next.rad  = {in_work.rad[RAD_W-3:0], 2'b00};
    work_next.rem  = ge ? REM_W'(cur - trial) : REM_W'(cur);
    work_next.root = {in_work.root[ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_side <= in_side;
      out_work <= work_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/qrs_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_div_cell: one quotient bit for both divider lanes
// Restoring step: shift in the next dividend bit, subtract the divisor when
// it fits and shift the quotient bit into the low end.
// ----------------------------------------------------------------------------
module qrs_div_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire qrs_pkg::div_side_t in_side,
  input  wire qrs_pkg::div_work_t in_work,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output qrs_pkg::div_side_t      out_side,
  output qrs_pkg::div_work_t      out_work
);
  import qrs_pkg::*;

  logic             valid;
  div_work_t        work_next;
  logic [DEN_W:0]   sh1;
  logic [DEN_W:0]   sh2;
  logic [DEN_W:0]   den_x;
  logic             ge1;
  logic             ge2;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  always_comb begin
    den_x = {1'b0, in_side.den};
    sh1   = {in_work.rem1, in_work.dq1[DVD_W-1]};
    sh2   = {in_work.rem2, in_work.dq2[DVD_W-1]};
    ge1   = sh1 >= den_x;
    ge2   = sh2 >= den_x;
    work_next.rem1 = ge1 ? DEN_W'(sh1 - den_x) : DEN_W'(sh1);
    work_next.rem2 = ge2 ? DEN_W'(sh2 - den_x) : DEN_W'(sh2);
    work_next.dq1  = {in_work.dq1[DVD_W-2:0], ge1};
    work_next.dq2  = {in_work.dq2[DVD_W-2:0], ge2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_side <= in_side;
      out_work <= work_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/qrs_out.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_out: sign, clip and result register
// Applies the quotient signs, clips each root part to Q16.16, zeroes the
// degenerate case and holds the result beat for the consumer.
// ----------------------------------------------------------------------------
module qrs_out (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire qrs_pkg::div_side_t in_side,
  input  wire qrs_pkg::div_work_t in_work,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              root_kind,
  output logic signed [31:0]      first_real,
  output logic signed [31:0]      first_imag,
  output logic signed [31:0]      second_real,
  output logic signed [31:0]      second_imag,
  output logic                    saturated
);
  import qrs_pkg::*;

  logic               valid;
  logic signed [34:0] v1p;
  logic signed [34:0] v2p;
  logic signed [34:0] v2n;
  logic signed [31:0] c1p;
  logic signed [31:0] c2p;
  logic signed [31:0] c2n;
  logic               s1p;
  logic               s2p;
  logic               s2n;
  logic signed [31:0] r1;
  logic signed [31:0] i1;
  logic signed [31:0] r2;
  logic signed [31:0] i2;
  logic               sat;

  function automatic logic [32:0] clip(input logic signed [34:0] v);
    logic [32:0] res;
    if (v > 35'sd2147483647) begin
      res = {1'b1, 32'h7fff_ffff};
    end else if (v < -35'sd2147483648) begin
      res = {1'b1, 32'h8000_0000};
    end else begin
      res = {1'b0, v[31:0]};
    end
    return res;
  endfunction

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  always_comb begin
    v1p = in_side.neg1 ? -$signed({1'b0, in_work.dq1}) : $signed({1'b0, in_work.dq1});
    v2p = in_side.neg2 ? -$signed({1'b0, in_work.dq2}) : $signed({1'b0, in_work.dq2});
    v2n = -v2p;
    {s1p, c1p} = clip(v1p);
    {s2p, c2p} = clip(v2p);
    {s2n, c2n} = clip(v2n);
    unique case (in_side.kind)
      KIND_REAL: begin
        r1  = c1p;
        r2  = c2p;
        i1  = '0;
        i2  = '0;
        sat = s1p || s2p;
      end
      KIND_COMPLEX: begin
        r1  = c1p;
        r2  = c1p;
        i1  = c2p;
        i2  = c2n;
        sat = s1p || s2p || s2n;
      end
      default: begin
        r1  = '0;
        r2  = '0;
        i1  = '0;
        i2  = '0;
        sat = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      root_kind   <= in_side.kind;
      first_real  <= r1;
      first_imag  <= i1;
      second_real <= r2;
      second_imag <= i2;
      saturated   <= sat;
    end
  end

endmodule
`default_nettype wire

>>> rtl/quadratic_root_solver_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quadratic_root_solver_unit: roots of a*x^2 + b*x + c in Q16.16
// Products and discriminant, a 32-cell square root chain, a 34-cell
// two-lane divider chain and a clip/result register.
//
//   channel  handshake             beat contents
//   in       in_valid / in_ready   coef_a, coef_b, coef_c (signed Q8.8)
//   out      out_valid / out_ready root_kind, four Q16.16 root parts, saturated
//
// One beat enters per cycle unless a stalled consumer has filled the chain; each
// beat passes the front, one cell per root or quotient bit and the result register.
// Every cell is a register stage with its own valid; a stalled consumer fills
// the chain from the end, and empty cells keep accepting meanwhile.
// Reset clears all valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module quadratic_root_solver_unit (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic signed [15:0]  coef_a,
  input  wire logic signed [15:0]  coef_b,
  input  wire logic signed [15:0]  coef_c,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [1:0]               root_kind,
  output logic signed [31:0]       first_real,
  output logic signed [31:0]       first_imag,
  output logic signed [31:0]       second_real,
  output logic signed [31:0]       second_imag,
  output logic                     saturated
);
  import qrs_pkg::*;

  logic       sq_valid [0:SQRT_STEPS];
  logic       sq_ready [0:SQRT_STEPS];
  sqrt_side_t sq_side  [0:SQRT_STEPS];
  sqrt_work_t sq_work  [0:SQRT_STEPS];

  logic       dv_valid [0:DIV_STEPS];
  logic       dv_ready [0:DIV_STEPS];
  div_side_t  dv_side  [0:DIV_STEPS];
  div_work_t  dv_work  [0:DIV_STEPS];

  logic signed [33:0] nb_x;
  logic signed [33:0] s_x;
  logic signed [33:0] n1;
  logic signed [33:0] n2;
  logic [32:0]        m1;
  logic [32:0]        m2;

  qrs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .coef_a    (coef_a),
    .coef_b    (coef_b),
    .coef_c    (coef_c),
    .out_valid (sq_valid[0]),
    .out_ready (sq_ready[0]),
    .out_side  (sq_side[0]),
    .out_work  (sq_work[0])
  );

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    qrs_sqrt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (sq_valid[i]),
      .in_ready  (sq_ready[i]),
      .in_side   (sq_side[i]),
      .in_work   (sq_work[i]),
      .out_valid (sq_valid[i+1]),
      .out_ready (sq_ready[i+1]),
      .out_side  (sq_side[i+1]),
      .out_work  (sq_work[i+1])
    );
  end

  always_comb begin
    nb_x = 34'(sq_side[SQRT_STEPS].nb);
    s_x  = $signed({2'b00, sq_work[SQRT_STEPS].root});
    if (sq_side[SQRT_STEPS].kind == KIND_COMPLEX) begin
      n1 = nb_x;
      n2 = s_x;
    end else begin
      n1 = nb_x + s_x;
      n2 = nb_x - s_x;
    end
    m1 = n1[33] ? 33'(-n1) : n1[32:0];
    m2 = n2[33] ? 33'(-n2) : n2[32:0];
    dv_side[0].kind = sq_side[SQRT_STEPS].kind;
    dv_side[0].neg1 = n1[33] ^ sq_side[SQRT_STEPS].a_neg;
    dv_side[0].neg2 = n2[33] ^ sq_side[SQRT_STEPS].a_neg;
    dv_side[0].den  = sq_side[SQRT_STEPS].a_mag;
    dv_work[0].dq1  = DVD_W'(m1) + DVD_W'(sq_side[SQRT_STEPS].a_mag >> 1);
    dv_work[0].dq2  = DVD_W'(m2) + DVD_W'(sq_side[SQRT_STEPS].a_mag >> 1);
    dv_work[0].rem1 = '0;
    dv_work[0].rem2 = '0;
  end

  assign dv_valid[0]          = sq_valid[SQRT_STEPS];
  assign sq_ready[SQRT_STEPS] = dv_ready[0];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    qrs_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (dv_valid[j]),
      .in_ready  (dv_ready[j]),
      .in_side   (dv_side[j]),
      .in_work   (dv_work[j]),
      .out_valid (dv_valid[j+1]),
      .out_ready (dv_ready[j+1]),
      .out_side  (dv_side[j+1]),
      .out_work  (dv_work[j+1])
    );
  end

  qrs_out u_out (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (dv_valid[DIV_STEPS]),
    .in_ready    (dv_ready[DIV_STEPS]),
    .in_side     (dv_side[DIV_STEPS]),
    .in_work     (dv_work[DIV_STEPS]),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .root_kind   (root_kind),
    .first_real  (first_real),
    .first_imag  (first_imag),
    .second_real (second_real),
    .second_imag (second_imag),
    .saturated   (saturated)
  );

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat valid right after reset");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && root_kind == KIND_DEGEN |->
      first_real == 0 && first_imag == 0 && second_real == 0 && second_imag == 0
      && !saturated)
    else $error("degenerate beat carries nonzero roots");

  a_real_imag_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && root_kind == KIND_REAL |-> first_imag == 0 && second_imag == 0)
    else $error("real roots with imaginary parts");

  a_complex_conj: assert property (@(posedge clk) disable iff (rst)
    out_valid && root_kind == KIND_COMPLEX |-> first_real == second_real)
    else $error("complex pair with unequal real parts");

endmodule
`default_nettype wire
